// ===== rtl/core/uart_byte_ring_pair_with_stats_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef UART_BYTE_RING_PAIR_WITH_STATS_ASSERT_SVH
`define UART_BYTE_RING_PAIR_WITH_STATS_ASSERT_SVH

// Clocked assertion that is switched off while reset is held low.
`define UBRP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define UBRP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ubrp_pkg.sv =====
package ubrp_pkg;

    // Ring depths and the pointer widths that follow from them.
    localparam int RX_DEPTH = 16384;
    localparam int TX_DEPTH = 4096;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);

    // Field widths.
    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int LVL_W  = 14;
    localparam int FREE_W = 12;
    localparam int CNT_W  = 32;
    localparam int PEAK_W = 16;

    // Stream payload widths.
    localparam int IN_DATA_W   = 16;
    localparam int OUT_FIELD_W = BYTE_W + LVL_W + FREE_W + 2 * PEAK_W + 6 * CNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // Command codes carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_RX_RECV  = 3'd0,
        CMD_RX_READ  = 3'd1,
        CMD_TX_WRITE = 3'd2,
        CMD_TX_SEND  = 3'd3,
        CMD_INT_END  = 3'd4,
        CMD_CLEAR    = 3'd5
    } t_cmd;

    // Status codes carried in the output tuser.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Saturating increments.
    function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [PEAK_W-1:0] sat_inc16(input logic [PEAK_W-1:0] v);
        return (&v) ? v : v + PEAK_W'(1);
    endfunction

    // Pointer advance with wrap at the ring depth.
    function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
    endfunction

    function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
    endfunction

endpackage

// ===== rtl/core/uart_byte_ring_pair_with_stats.sv =====
// Latency: the result beat of an item is valid in the cycle after its input beat is taken.
// Throughput: one beat per cycle; the input accepts whenever the output register is empty
// or is being drained, and each item needs at most one access to one of the two ring memories.
// Reset (synchronous, active low) zeroes pointers, tallies, peaks and counters and empties
// the output register; ring memory contents are not cleared and need no clearing pass.
module uart_byte_ring_pair_with_stats (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [7:0] data_byte, [8] overrun_seen, [9] frame_noise_seen, [15:10] zero
    input  logic [ubrp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [2:0] command
    input  logic [ubrp_pkg::CMD_W-1:0]      i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] out_byte, [21:8] rx_level, [33:22] tx_free, [65:34] rx_drop_total,
    // [81:66] rx_burst_peak, [97:82] tx_burst_peak, [129:98] interrupt_total,
    // [161:130] tx_sent_total, [193:162] tx_active_interrupts,
    // [225:194] overrun_total, [257:226] frame_error_total, [263:258] zero
    output logic [ubrp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [ubrp_pkg::STAT_W-1:0]     o_m_axis_tuser
);
    import ubrp_pkg::*;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_RX,
        SRC_TX
    } t_src;

    // Ring memories and their registered read data.
    logic [BYTE_W-1:0] r_rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] r_tx_mem [TX_DEPTH];
    logic [BYTE_W-1:0] r_rx_rd;
    logic [BYTE_W-1:0] r_tx_rd;

    // Control and statistics state.
    logic              r_m_valid;
    t_status           r_status,    n_status;
    t_src              r_src,       n_src;
    logic [RX_AW-1:0]  r_rx_wp,     n_rx_wp;
    logic [RX_AW-1:0]  r_rx_rp,     n_rx_rp;
    logic [TX_AW-1:0]  r_tx_wp,     n_tx_wp;
    logic [TX_AW-1:0]  r_tx_rp,     n_tx_rp;
    logic [PEAK_W-1:0] r_burst_rx,  n_burst_rx;
    logic [PEAK_W-1:0] r_burst_tx,  n_burst_tx;
    logic [PEAK_W-1:0] r_rx_peak,   n_rx_peak;
    logic [PEAK_W-1:0] r_tx_peak,   n_tx_peak;
    logic [CNT_W-1:0]  r_drop_cnt,  n_drop_cnt;
    logic [CNT_W-1:0]  r_int_cnt,   n_int_cnt;
    logic [CNT_W-1:0]  r_txb_cnt,   n_txb_cnt;
    logic [CNT_W-1:0]  r_txi_cnt,   n_txi_cnt;
    logic [CNT_W-1:0]  r_ore_cnt,   n_ore_cnt;
    logic [CNT_W-1:0]  r_fe_cnt,    n_fe_cnt;

    logic              accept;
    t_cmd              cmd;
    logic [BYTE_W-1:0] in_byte;
    logic              in_ovr;
    logic              in_fe;
    logic              rx_wr_en;
    logic              rx_rd_en;
    logic              tx_wr_en;
    logic              tx_rd_en;
    logic [RX_AW:0]    rx_used;
    logic [TX_AW:0]    tx_used;
    logic [LVL_W-1:0]  rx_level;
    logic [FREE_W-1:0] tx_free;
    logic [BYTE_W-1:0] out_byte;

    // Input decode and handshake.
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign cmd             = t_cmd'(i_s_axis_tuser);
    assign in_byte         = i_s_axis_tdata[BYTE_W-1:0];
    assign in_ovr          = i_s_axis_tdata[BYTE_W];
    assign in_fe           = i_s_axis_tdata[BYTE_W+1];

    // Next state for the command in the input beat.
    always_comb begin
        n_status   = ST_OK;
        n_src      = SRC_NONE;
        n_rx_wp    = r_rx_wp;
        n_rx_rp    = r_rx_rp;
        n_tx_wp    = r_tx_wp;
        n_tx_rp    = r_tx_rp;
        n_burst_rx = r_burst_rx;
        n_burst_tx = r_burst_tx;
        n_rx_peak  = r_rx_peak;
        n_tx_peak  = r_tx_peak;
        n_drop_cnt = r_drop_cnt;
        n_int_cnt  = r_int_cnt;
        n_txb_cnt  = r_txb_cnt;
        n_txi_cnt  = r_txi_cnt;
        n_ore_cnt  = r_ore_cnt;
        n_fe_cnt   = r_fe_cnt;
        rx_wr_en   = 1'b0;
        rx_rd_en   = 1'b0;
        tx_wr_en   = 1'b0;
        tx_rd_en   = 1'b0;
        case (cmd)
            CMD_RX_RECV: begin
                n_burst_rx = sat_inc16(r_burst_rx);
                if (rx_next(r_rx_wp) == r_rx_rp) begin
                    n_drop_cnt = sat_inc32(r_drop_cnt);
                    n_status   = ST_FULL;
                end else begin
                    rx_wr_en = accept;
                    n_rx_wp  = rx_next(r_rx_wp);
                end
            end
            CMD_RX_READ: begin
                if (r_rx_rp == r_rx_wp) begin
                    n_status = ST_EMPTY;
                end else begin
                    rx_rd_en = accept;
                    n_src    = SRC_RX;
                    n_rx_rp  = rx_next(r_rx_rp);
                end
            end
            CMD_TX_WRITE: begin
                if (tx_next(r_tx_wp) == r_tx_rp) begin
                    n_status = ST_FULL;
                end else begin
                    tx_wr_en = accept;
                    n_tx_wp  = tx_next(r_tx_wp);
                end
            end
            CMD_TX_SEND: begin
                if (r_tx_rp == r_tx_wp) begin
                    n_status = ST_EMPTY;
                end else begin
                    tx_rd_en   = accept;
                    n_src      = SRC_TX;
                    n_tx_rp    = tx_next(r_tx_rp);
                    n_burst_tx = sat_inc16(r_burst_tx);
                    n_txb_cnt  = sat_inc32(r_txb_cnt);
                end
            end
            CMD_INT_END: begin
                if (in_ovr) begin
                    n_ore_cnt = sat_inc32(r_ore_cnt);
                end
                if (in_fe) begin
                    n_fe_cnt = sat_inc32(r_fe_cnt);
                end
                if (r_burst_rx > r_rx_peak) begin
                    n_rx_peak = r_burst_rx;
                end
                if (r_burst_tx != '0) begin
                    n_txi_cnt = sat_inc32(r_txi_cnt);
                    if (r_burst_tx > r_tx_peak) begin
                        n_tx_peak = r_burst_tx;
                    end
                end
                n_burst_rx = '0;
                n_burst_tx = '0;
                n_int_cnt  = sat_inc32(r_int_cnt);
            end
            CMD_CLEAR: begin
                n_rx_wp    = '0;
                n_rx_rp    = '0;
                n_tx_wp    = '0;
                n_tx_rp    = '0;
                n_burst_rx = '0;
                n_burst_tx = '0;
                n_rx_peak  = '0;
                n_tx_peak  = '0;
                n_drop_cnt = '0;
                n_int_cnt  = '0;
                n_txb_cnt  = '0;
                n_txi_cnt  = '0;
                n_ore_cnt  = '0;
                n_fe_cnt   = '0;
            end
            default: begin
            end
        endcase
    end

    // Receive ring memory: one write or one read per beat.
    always_ff @(posedge i_clk) begin
        if (rx_wr_en) begin
            r_rx_mem[r_rx_wp] <= in_byte;
        end
        if (rx_rd_en) begin
            r_rx_rd <= r_rx_mem[r_rx_rp];
        end
    end

    // Transmit ring memory: one write or one read per beat.
    always_ff @(posedge i_clk) begin
        if (tx_wr_en) begin
            r_tx_mem[r_tx_wp] <= in_byte;
        end
        if (tx_rd_en) begin
            r_tx_rd <= r_tx_mem[r_tx_rp];
        end
    end

    // State update on each accepted beat, output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid  <= 1'b0;
            r_status   <= ST_OK;
            r_src      <= SRC_NONE;
            r_rx_wp    <= '0;
            r_rx_rp    <= '0;
            r_tx_wp    <= '0;
            r_tx_rp    <= '0;
            r_burst_rx <= '0;
            r_burst_tx <= '0;
            r_rx_peak  <= '0;
            r_tx_peak  <= '0;
            r_drop_cnt <= '0;
            r_int_cnt  <= '0;
            r_txb_cnt  <= '0;
            r_txi_cnt  <= '0;
            r_ore_cnt  <= '0;
            r_fe_cnt   <= '0;
        end else begin
            if (accept) begin
                r_m_valid  <= 1'b1;
                r_status   <= n_status;
                r_src      <= n_src;
                r_rx_wp    <= n_rx_wp;
                r_rx_rp    <= n_rx_rp;
                r_tx_wp    <= n_tx_wp;
                r_tx_rp    <= n_tx_rp;
                r_burst_rx <= n_burst_rx;
                r_burst_tx <= n_burst_tx;
                r_rx_peak  <= n_rx_peak;
                r_tx_peak  <= n_tx_peak;
                r_drop_cnt <= n_drop_cnt;
                r_int_cnt  <= n_int_cnt;
                r_txb_cnt  <= n_txb_cnt;
                r_txi_cnt  <= n_txi_cnt;
                r_ore_cnt  <= n_ore_cnt;
                r_fe_cnt   <= n_fe_cnt;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Ring occupancy from the pointers; the state registers hold until the beat drains.
    always_comb begin
        if (r_rx_wp >= r_rx_rp) begin
            rx_used = {1'b0, r_rx_wp} - {1'b0, r_rx_rp};
        end else begin
            rx_used = {1'b0, r_rx_wp} + (RX_AW + 1)'(RX_DEPTH) - {1'b0, r_rx_rp};
        end
        if (r_tx_wp >= r_tx_rp) begin
            tx_used = {1'b0, r_tx_wp} - {1'b0, r_tx_rp};
        end else begin
            tx_used = {1'b0, r_tx_wp} + (TX_AW + 1)'(TX_DEPTH) - {1'b0, r_tx_rp};
        end
    end

    assign rx_level = LVL_W'(rx_used);
    assign tx_free  = FREE_W'((TX_AW + 1)'(TX_DEPTH - 1) - tx_used);

    // Byte shown in the result beat.
    always_comb begin
        case (r_src)
            SRC_RX:  out_byte = r_rx_rd;
            SRC_TX:  out_byte = r_tx_rd;
            default: out_byte = '0;
        endcase
    end

    // Output beat.
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_fe_cnt, r_ore_cnt, r_txi_cnt, r_txb_cnt,
                              r_int_cnt, r_tx_peak, r_rx_peak, r_drop_cnt, tx_free,
                              rx_level, out_byte};

endmodule

// ===== rtl/core/ubrp_checker.sv =====
`include "uart_byte_ring_pair_with_stats_assert.svh"

module ubrp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [ubrp_pkg::CMD_W-1:0]      i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [ubrp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [ubrp_pkg::STAT_W-1:0]     o_m_axis_tuser
);
    import ubrp_pkg::*;

    logic                         in_beat;
    logic                         int_beat;
    logic                         out_idle;
    logic                         out_stall;
    logic [STAT_W+OUT_DATA_W-1:0] out_beat;
    logic [CNT_W-1:0]             int_total;

    assign in_beat   = i_s_axis_tvalid && o_s_axis_tready;
    assign int_beat  = in_beat && (i_s_axis_tuser != CMD_CLEAR);
    assign out_idle  = !o_m_axis_tvalid;
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_beat  = {o_m_axis_tuser, o_m_axis_tdata};
    assign int_total = o_m_axis_tdata[129:98];

    // Reset empties the output register.
    `UBRP_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "valid after reset")

    // Every accepted input beat produces a result beat in the next cycle.
    `UBRP_ASSERT(a_in_to_out, i_clk, i_rst_n, in_beat |=> o_m_axis_tvalid, "result beat missing")

    // An empty output register never blocks the input.
    `UBRP_ASSERT(a_ready_empty, i_clk, i_rst_n, out_idle |-> o_s_axis_tready, "input blocked")

    // A stalled result beat keeps its payload and status.
    `UBRP_ASSERT(a_hold, i_clk, i_rst_n, out_stall |=> $stable(out_beat), "stalled beat changed")

    // The interrupt count only falls through a clear command.
    `UBRP_ASSERT(a_int_up, i_clk, i_rst_n, int_beat |=> int_total >= $past(int_total), "count fell")

endmodule

bind uart_byte_ring_pair_with_stats ubrp_checker u_ubrp_checker (.*);

// ===== sim/tb_uart_byte_ring_pair_with_stats.sv =====
`timescale 1ns / 1ps

module tb_uart_byte_ring_pair_with_stats;
    import ubrp_pkg::*;

    // Command codes that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 480;
    localparam int MAX_REPORTS  = 100;

    // Result beat layout; the lowest field of tdata is the last member.
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [CNT_W-1:0]     frame_errs;
        logic [CNT_W-1:0]     overruns;
        logic [CNT_W-1:0]     busy_irqs;
        logic [CNT_W-1:0]     sent;
        logic [CNT_W-1:0]     irqs;
        logic [PEAK_W-1:0]    tx_peak;
        logic [PEAK_W-1:0]    rx_peak;
        logic [CNT_W-1:0]     drops;
        logic [FREE_W-1:0]    tx_free;
        logic [LVL_W-1:0]     rx_level;
        logic [BYTE_W-1:0]    out_byte;
    } ring_stats_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        ring_stats_t       stats;
    } ring_result_t;

    // Tracks both rings and all tallies, and holds the results still owed by the block.
    class ring_pair_scoreboard;
        logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
        logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
        logic [RX_AW-1:0]  rx_wr, rx_rd;
        logic [TX_AW-1:0]  tx_wr, tx_rd;
        logic [PEAK_W-1:0] rx_burst, tx_burst, rx_peak, tx_peak;
        logic [CNT_W-1:0]  drops, irqs, sent, busy_irqs, overruns, frame_errs;
        ring_result_t      owed_q[$];
        int                fails;

        function new();
            wipe();
            fails = 0;
        endfunction

        function void wipe();
            rx_wr      = '0;
            rx_rd      = '0;
            tx_wr      = '0;
            tx_rd      = '0;
            rx_burst   = '0;
            tx_burst   = '0;
            rx_peak    = '0;
            tx_peak    = '0;
            drops      = '0;
            irqs       = '0;
            sent       = '0;
            busy_irqs  = '0;
            overruns   = '0;
            frame_errs = '0;
        endfunction

        // Apply one accepted input beat and queue the result it must produce.
        function void note_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                logic ovr, logic fe);
            ring_result_t     r;
            logic [TX_AW-1:0] tx_used;
            r.status = ST_OK;
            r.stats  = '0;
            case (cmd)
                CMD_RX_RECV: begin
                    if (~&rx_burst) rx_burst++;
                    if (RX_AW'(rx_wr + 1'b1) == rx_rd) begin
                        if (~&drops) drops++;
                        r.status = ST_FULL;
                    end else begin
                        rx_mem[rx_wr] = data;
                        rx_wr++;
                    end
                end
                CMD_RX_READ: begin
                    if (rx_rd == rx_wr) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.stats.out_byte = rx_mem[rx_rd];
                        rx_rd++;
                    end
                end
                CMD_TX_WRITE: begin
                    if (TX_AW'(tx_wr + 1'b1) == tx_rd) begin
                        r.status = ST_FULL;
                    end else begin
                        tx_mem[tx_wr] = data;
                        tx_wr++;
                    end
                end
                CMD_TX_SEND: begin
                    if (tx_rd == tx_wr) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.stats.out_byte = tx_mem[tx_rd];
                        tx_rd++;
                        if (~&tx_burst) tx_burst++;
                        if (~&sent) sent++;
                    end
                end
                CMD_INT_END: begin
                    // Fold the burst tallies into the peaks, then start a new burst.
                    if (ovr && ~&overruns) overruns++;
                    if (fe && ~&frame_errs) frame_errs++;
                    if (rx_burst > rx_peak) rx_peak = rx_burst;
                    if (tx_burst != 0) begin
                        if (~&busy_irqs) busy_irqs++;
                        if (tx_burst > tx_peak) tx_peak = tx_burst;
                    end
                    rx_burst = '0;
                    tx_burst = '0;
                    if (~&irqs) irqs++;
                end
                CMD_CLEAR: begin
                    wipe();
                end
                default: begin
                end
            endcase
            tx_used              = tx_wr - tx_rd;
            r.stats.rx_level     = rx_wr - rx_rd;
            r.stats.tx_free      = FREE_W'(TX_DEPTH - 1) - tx_used;
            r.stats.drops        = drops;
            r.stats.rx_peak      = rx_peak;
            r.stats.tx_peak      = tx_peak;
            r.stats.irqs         = irqs;
            r.stats.sent         = sent;
            r.stats.busy_irqs    = busy_irqs;
            r.stats.overruns     = overruns;
            r.stats.frame_errs   = frame_errs;
            owed_q.push_back(r);
        endfunction

        function void compare(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                fails++;
                // Keep the log short if the block goes badly wrong.
                if (fails <= MAX_REPORTS)
                    $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        // Compare one accepted result beat with the oldest owed result.
        function void check_result(logic [STAT_W-1:0] status, logic [OUT_DATA_W-1:0] data);
            ring_result_t want;
            ring_stats_t  got;
            got = data;
            if (owed_q.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $error("result beat with no result owed: status %0d", status);
            end else begin
                want = owed_q.pop_front();
                compare("status", CNT_W'(want.status), CNT_W'(status));
                compare("out_byte", CNT_W'(want.stats.out_byte), CNT_W'(got.out_byte));
                compare("rx_level", CNT_W'(want.stats.rx_level), CNT_W'(got.rx_level));
                compare("tx_free", CNT_W'(want.stats.tx_free), CNT_W'(got.tx_free));
                compare("rx_drop_total", want.stats.drops, got.drops);
                compare("rx_burst_peak", CNT_W'(want.stats.rx_peak), CNT_W'(got.rx_peak));
                compare("tx_burst_peak", CNT_W'(want.stats.tx_peak), CNT_W'(got.tx_peak));
                compare("interrupt_total", want.stats.irqs, got.irqs);
                compare("tx_sent_total", want.stats.sent, got.sent);
                compare("tx_active_interrupts", want.stats.busy_irqs, got.busy_irqs);
                compare("overrun_total", want.stats.overruns, got.overruns);
                compare("frame_error_total", want.stats.frame_errs, got.frame_errs);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_ready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic [STAT_W-1:0]      o_m_axis_tuser;

    // When set, neither side idles at random.
    bit                     steady = 1'b0;
    // Asks the receiver for one long hold-off.
    bit                     hold_req = 1'b0;
    int                     quiet_cycles = 0;
    ring_pair_scoreboard    sb = new();

    uart_byte_ring_pair_with_stats dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Offer one input beat, with an optional random gap first, and wait until it is taken.
    task automatic push_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                             logic ovr, logic fe);
        if (!steady) begin
            while ($urandom_range(99) < 27) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(IN_DATA_W - 10){1'b0}}, fe, ovr, data};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!steady && $urandom_range(99) < 27) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Sample both handshakes at the edge; note inputs before checking results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready)
                sb.note_item(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]);
            if (o_m_axis_tvalid && m_ready)
                sb.check_result(o_m_axis_tuser, o_m_axis_tdata);
        end
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("uart_byte_ring_pair_with_stats: mismatch");
            $finish;
        end
    end

    initial begin
        int          i;
        int unsigned pick;
        logic [CMD_W-1:0] cmd;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty rings, ignored codes, byte extremes and every flag combination.
        push_item(CMD_RX_READ, 8'h00, 1'b0, 1'b0);
        push_item(CMD_TX_SEND, 8'hFF, 1'b1, 1'b1);
        push_item(CMD_SPARE_A, 8'hFF, 1'b1, 1'b1);
        push_item(CMD_SPARE_B, 8'h5A, 1'b1, 1'b0);
        push_item(CMD_RX_RECV, 8'h00, 1'b1, 1'b1);
        push_item(CMD_RX_RECV, 8'hFF, 1'b0, 1'b0);
        push_item(CMD_RX_RECV, 8'hA5, 1'b0, 1'b1);
        push_item(CMD_TX_WRITE, 8'hFF, 1'b0, 1'b1);
        push_item(CMD_TX_WRITE, 8'h00, 1'b1, 1'b0);
        push_item(CMD_TX_SEND, 8'h00, 1'b0, 1'b0);
        push_item(CMD_TX_SEND, 8'h00, 1'b0, 1'b0);
        push_item(CMD_TX_SEND, 8'h00, 1'b0, 1'b0);
        push_item(CMD_INT_END, 8'h00, 1'b0, 1'b0);
        push_item(CMD_RX_READ, 8'h00, 1'b0, 1'b0);
        push_item(CMD_RX_READ, 8'h00, 1'b0, 1'b0);
        push_item(CMD_RX_READ, 8'h00, 1'b0, 1'b0);
        push_item(CMD_RX_READ, 8'h00, 1'b0, 1'b0);
        push_item(CMD_INT_END, 8'hFF, 1'b1, 1'b0);
        push_item(CMD_INT_END, 8'h00, 1'b0, 1'b1);
        push_item(CMD_INT_END, 8'h00, 1'b1, 1'b1);
        push_item(CMD_CLEAR, 8'hFF, 1'b1, 1'b1);

        // Random traffic shaped like interrupt bursts, with rare clears and junk codes.
        // One stretch runs with no idling on either side.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100)
                hold_req = 1'b1;
            if (i == 300)
                steady = 1'b1;
            if (i == 400)
                steady = 1'b0;
            pick = $urandom_range(99);
            if (pick < 25)
                cmd = CMD_RX_RECV;
            else if (pick < 45)
                cmd = CMD_RX_READ;
            else if (pick < 65)
                cmd = CMD_TX_WRITE;
            else if (pick < 85)
                cmd = CMD_TX_SEND;
            else if (pick < 95)
                cmd = CMD_INT_END;
            else if (pick < 97)
                cmd = CMD_CLEAR;
            else
                cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
            push_item(cmd, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
        end
        s_valid <= 1'b0;

        // Wait for every owed result, then a few more cycles for stray beats.
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.fails == 0)
            $display("uart_byte_ring_pair_with_stats: match");
        else
            $display("uart_byte_ring_pair_with_stats: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ubrp_pkg.sv
rtl/core/uart_byte_ring_pair_with_stats.sv
rtl/core/ubrp_checker.sv
sim/tb_uart_byte_ring_pair_with_stats.sv
